[hw/rtl/ppi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared types and constants for the particle pool integrator.
// ----------------------------------------------------------------------------
package ppi_pkg;

   localparam int PoolSize  = 64;
   localparam int SlotW     = 6;
   localparam int QW        = 24;
   localparam int CornerW   = 26;
   localparam int RadiusW   = 16;
   localparam int LifeW     = 10;
   localparam int AlphaW    = 8;
   localparam int CsrAddrW  = 4;

   localparam logic [AlphaW-1:0] AlphaFull = 8'd255;

   localparam logic [1:0] RegForce   = 2'd0;
   localparam logic [1:0] RegWindX   = 2'd1;
   localparam logic [1:0] RegWindY   = 2'd2;
   localparam logic [1:0] RegGravity = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DIVIDE,
      ST_WRITE,
      ST_READ,
      ST_UPDATE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic             latch_req;   // capture request fields
      logic             clr_slot;    // slot counter to zero
      logic             inc_slot;
      logic             div_start;
      logic             div_step;
      logic             spawn_write;
      logic             mem_read;    // read slot into stage
      logic             upd_write;   // write back updated slot, maybe emit
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic             kind;
      logic             slot_used;   // in_use of current slot
      logic             slot_end;    // current slot is the final one
      logic             div_done;
   } stat_type;

   function automatic logic [QW-1:0] sat_add(input logic [QW-1:0] a,
                                              input logic [QW-1:0] b);
      logic [QW:0] s;
      s = {a[QW-1], a} + {b[QW-1], b};
      if (s[QW] != s[QW-1])
         sat_add = s[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      else
         sat_add = s[QW-1:0];
   endfunction

endpackage

[hw/rtl/ppi_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppi_ctrl
// Sequencer: spawn search and fade divide, tick slot sweep.
// ----------------------------------------------------------------------------
module ppi_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ppi_pkg::stat_type stat,
   output ppi_pkg::cmd_type  cmd
);
   import ppi_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               cmd.clr_slot  = 1'b1;
               state_in      = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (stat.kind) begin
               if (!stat.slot_used) begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIVIDE;
               end else if (stat.slot_end) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.inc_slot = 1'b1;
               end
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.spawn_write = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.upd_write = 1'b1;
            if (stat.slot_end) begin
               state_in = ST_IDLE;
            end else begin
               cmd.inc_slot = 1'b1;
               state_in     = ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_write_from_divide: assert property (@(posedge clock) disable iff (reset)
      cmd.spawn_write |-> $past(state_ff) == ST_DIVIDE)
      else $error("spawn write without divide");
   a_update_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |-> $past(state_ff) == ST_READ)
      else $error("update without read");
   a_idle_not_busy: assert property (@(posedge clock) disable iff (reset)
      busy == (state_ff != ST_IDLE))
      else $error("busy mismatch");

endmodule

[hw/rtl/ppi_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppi_datapath
// Particle memory, valid bits, fade divider, integration and corner output.
// ----------------------------------------------------------------------------
module ppi_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ppi_pkg::cmd_type                     cmd,
   output ppi_pkg::stat_type                    stat,
   input  logic                                 req_kind,
   input  logic signed [ppi_pkg::QW-1:0]        req_pos_x,
   input  logic signed [ppi_pkg::QW-1:0]        req_pos_y,
   input  logic signed [ppi_pkg::QW-1:0]        req_vel_x,
   input  logic signed [ppi_pkg::QW-1:0]        req_vel_y,
   input  logic [ppi_pkg::RadiusW-1:0]          req_radius,
   input  logic [ppi_pkg::LifeW-1:0]            req_life,
   input  logic                                 req_follows_camera,
   input  logic signed [ppi_pkg::QW-1:0]        req_scroll_offset,
   input  logic                                 force_enable,
   input  logic signed [ppi_pkg::QW-1:0]        wind_x,
   input  logic signed [ppi_pkg::QW-1:0]        wind_y,
   input  logic signed [ppi_pkg::QW-1:0]        gravity,
   output logic                                 rsp_valid,
   output logic [ppi_pkg::SlotW-1:0]            rsp_slot,
   output logic signed [ppi_pkg::CornerW-1:0]   rsp_left,
   output logic signed [ppi_pkg::CornerW-1:0]   rsp_right,
   output logic signed [ppi_pkg::CornerW-1:0]   rsp_top,
   output logic signed [ppi_pkg::CornerW-1:0]   rsp_bottom,
   output logic [ppi_pkg::AlphaW-1:0]           rsp_alpha,
   output logic                                 rsp_last
);
   import ppi_pkg::*;

   typedef struct packed {
      logic [QW-1:0]      x;
      logic [QW-1:0]      y;
      logic [QW-1:0]      vx;
      logic [QW-1:0]      vy;
      logic [RadiusW-1:0] r;
      logic [LifeW-1:0]   life;
      logic [AlphaW-1:0]  alpha;
      logic [AlphaW-1:0]  fade;
      logic               cam;
   } ent_type;

   ent_type mem [PoolSize];
   ent_type rd_ff;

   logic [PoolSize-1:0] used_ff;
   logic [SlotW-1:0]    slot_ff;
   logic                kind_ff;
   ent_type             req_ff;
   logic [QW-1:0]       scroll_ff;

   // restoring divider 255 / life, one quotient bit per cycle
   logic [LifeW-1:0]    div_rem_ff;
   logic [AlphaW-1:0]   div_q_ff;
   logic [3:0]          div_cnt_ff;
   logic [LifeW:0]      div_trial;

   logic [LifeW-1:0]    life_clamp;
   ent_type             upd;
   logic [QW-1:0]       vx1, vy1, vy2;
   logic [CornerW-1:0]  xe, ye, re, oe;
   logic                was_used_ff;
   logic [SlotW-1:0]    rd_slot_ff;

   assign life_clamp = (req_life == '0) ? LifeW'(1) : req_life;
   assign div_trial  = {div_rem_ff, div_q_ff[AlphaW-1]} - {1'b0, req_ff.life};

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         kind_ff      <= req_kind;
         req_ff.x     <= req_pos_x;
         req_ff.y     <= req_pos_y;
         req_ff.vx    <= req_vel_x;
         req_ff.vy    <= req_vel_y;
         req_ff.r     <= req_radius;
         req_ff.life  <= life_clamp;
         req_ff.alpha <= AlphaFull;
         req_ff.fade  <= '0;
         req_ff.cam   <= req_follows_camera;
         scroll_ff    <= req_scroll_offset;
      end
      if (cmd.div_start) begin
         div_rem_ff <= '0;
         div_q_ff   <= AlphaFull;
         div_cnt_ff <= '0;
      end else if (cmd.div_step && div_cnt_ff != 4'(AlphaW)) begin
         if (!div_trial[LifeW]) begin
            div_rem_ff <= div_trial[LifeW-1:0];
            div_q_ff   <= {div_q_ff[AlphaW-2:0], 1'b1};
         end else begin
            div_rem_ff <= {div_rem_ff[LifeW-2:0], div_q_ff[AlphaW-1]};
            div_q_ff   <= {div_q_ff[AlphaW-2:0], 1'b0};
         end
         div_cnt_ff <= div_cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) slot_ff <= '0;
      else if (cmd.clr_slot) slot_ff <= '0;
      else if (cmd.inc_slot) slot_ff <= slot_ff + SlotW'(1);
   end

   // particle memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.spawn_write) begin
         mem[slot_ff] <= '{x: req_ff.x, y: req_ff.y, vx: req_ff.vx, vy: req_ff.vy,
                           r: req_ff.r, life: req_ff.life, alpha: AlphaFull,
                           fade: div_q_ff, cam: req_ff.cam};
      end else if (cmd.upd_write) begin
         mem[slot_ff] <= upd;
      end
      if (cmd.mem_read) rd_ff <= mem[slot_ff];
   end

   always_comb begin
      vx1 = force_enable ? sat_add(rd_ff.vx, wind_x) : rd_ff.vx;
      vy1 = force_enable ? sat_add(rd_ff.vy, wind_y) : rd_ff.vy;
      vy2 = force_enable ? sat_add(vy1, gravity) : rd_ff.vy;
      upd       = rd_ff;
      upd.vx    = vx1;
      upd.vy    = vy2;
      upd.x     = sat_add(rd_ff.x, vx1);
      upd.y     = sat_add(rd_ff.y, vy2);
      upd.life  = (rd_ff.life != '0) ? rd_ff.life - LifeW'(1) : '0;
      upd.alpha = (rd_ff.alpha > rd_ff.fade) ? rd_ff.alpha - rd_ff.fade : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) used_ff <= '0;
      else if (cmd.spawn_write) used_ff[slot_ff] <= 1'b1;
      else if (cmd.upd_write && upd.life == '0) used_ff[slot_ff] <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         was_used_ff <= used_ff[slot_ff];
         rd_slot_ff  <= slot_ff;
      end
   end

   // emit is registered behind update to keep the corner adders off the sat path
   logic               em_v_ff;
   logic               em_end_ff;
   ent_type            em_ff;
   logic [SlotW-1:0]   em_slot_ff;
   logic [CornerW-1:0] l_in, r_in, t_in, b_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         em_v_ff   <= 1'b0;
         em_end_ff <= 1'b0;
      end else begin
         em_v_ff   <= cmd.upd_write && was_used_ff && upd.life != '0;
         em_end_ff <= cmd.upd_write && slot_ff == SlotW'(PoolSize-1);
      end
      em_ff      <= upd;
      em_slot_ff <= rd_slot_ff;
   end

   // last is decided once the later slots are known: hold each result until
   // the next live slot arrives or the sweep has ended
   logic               flush_ff;
   logic               out_v_ff;
   logic               hold_v_ff;
   logic [SlotW-1:0]   hold_slot_ff;
   logic [CornerW-1:0] hold_l_ff, hold_r_ff, hold_t_ff, hold_b_ff;
   logic [AlphaW-1:0]  hold_a_ff;
   logic               send_mid, send_end;

   assign xe = CornerW'($signed(em_ff.x));
   assign ye = CornerW'($signed(em_ff.y));
   assign re = CornerW'(em_ff.r);
   assign oe = em_ff.cam ? CornerW'($signed(scroll_ff)) : '0;
   assign l_in = xe - re - oe;
   assign r_in = xe + re - oe;
   assign t_in = ye - re;
   assign b_in = ye + re;

   assign send_mid = em_v_ff && hold_v_ff;
   assign send_end = flush_ff && hold_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flush_ff  <= 1'b0;
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         flush_ff <= em_end_ff;
         out_v_ff <= send_mid || send_end;
         if (em_v_ff)       hold_v_ff <= 1'b1;
         else if (flush_ff) hold_v_ff <= 1'b0;
      end
      if (em_v_ff) begin
         hold_slot_ff <= em_slot_ff;
         hold_l_ff    <= l_in;
         hold_r_ff    <= r_in;
         hold_t_ff    <= t_in;
         hold_b_ff    <= b_in;
         hold_a_ff    <= em_ff.alpha;
      end
      if (send_mid || send_end) begin
         rsp_slot   <= hold_slot_ff;
         rsp_left   <= hold_l_ff;
         rsp_right  <= hold_r_ff;
         rsp_top    <= hold_t_ff;
         rsp_bottom <= hold_b_ff;
         rsp_alpha  <= hold_a_ff;
         rsp_last   <= send_end;
      end
   end

   assign rsp_valid = out_v_ff;

   assign stat.kind      = kind_ff;
   assign stat.slot_used = used_ff[slot_ff];
   assign stat.slot_end  = (slot_ff == SlotW'(PoolSize-1));
   assign stat.div_done  = (div_cnt_ff == 4'(AlphaW));

   a_spawn_free: assert property (@(posedge clock) disable iff (reset)
      cmd.spawn_write |-> !used_ff[slot_ff])
      else $error("spawn into live slot");
   a_emit_follows_update: assert property (@(posedge clock) disable iff (reset)
      em_v_ff |-> $past(cmd.upd_write))
      else $error("emit without update");
   a_div_done_bits: assert property (@(posedge clock) disable iff (reset)
      cmd.spawn_write |-> div_cnt_ff == 4'(AlphaW))
      else $error("fade not ready");

endmodule

[hw/rtl/particle_pool_integrator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_pool_integrator
// Particle pool with Euler integration, APB control registers.
// ----------------------------------------------------------------------------
// Spawn: free-slot scan one slot a cycle, fade divide, write; a spawn into a full
//   pool is dropped. Tick: one memory read and one write per slot, on the write
//   port and the registered read port of the particle memory. A result leaves once
//   the next live slot is known; the final one once the sweep end has passed the
//   em_end and flush registers. Results never stall. Reset clears the valid bits,
//   state and force values and sets force enable; particle data is left as is.
module particle_pool_integrator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_kind,
   input  logic signed [ppi_pkg::QW-1:0]        req_pos_x,
   input  logic signed [ppi_pkg::QW-1:0]        req_pos_y,
   input  logic signed [ppi_pkg::QW-1:0]        req_vel_x,
   input  logic signed [ppi_pkg::QW-1:0]        req_vel_y,
   input  logic [ppi_pkg::RadiusW-1:0]          req_radius,
   input  logic [ppi_pkg::LifeW-1:0]            req_life,
   input  logic                                 req_follows_camera,
   input  logic signed [ppi_pkg::QW-1:0]        req_scroll_offset,
   output logic                                 rsp_valid,
   output logic [ppi_pkg::SlotW-1:0]            rsp_slot,
   output logic signed [ppi_pkg::CornerW-1:0]   rsp_left,
   output logic signed [ppi_pkg::CornerW-1:0]   rsp_right,
   output logic signed [ppi_pkg::CornerW-1:0]   rsp_top,
   output logic signed [ppi_pkg::CornerW-1:0]   rsp_bottom,
   output logic [ppi_pkg::AlphaW-1:0]           rsp_alpha,
   output logic                                 rsp_last,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ppi_pkg::CsrAddrW-1:0]         paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import ppi_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic            force_ff;
   logic [QW-1:0]   wind_x_ff, wind_y_ff, gravity_ff;
   logic            wr;
   logic [1:0]      reg_idx;

   assign pready  = 1'b1;
   assign wr      = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         force_ff   <= 1'b1;
         wind_x_ff  <= '0;
         wind_y_ff  <= '0;
         gravity_ff <= '0;
      end else if (wr) begin
         case (reg_idx)
            RegForce:   force_ff   <= pwdata[0];
            RegWindX:   wind_x_ff  <= pwdata[QW-1:0];
            RegWindY:   wind_y_ff  <= pwdata[QW-1:0];
            RegGravity: gravity_ff <= pwdata[QW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         RegForce:   prdata = {31'd0, force_ff};
         RegWindX:   prdata = {{(32-QW){wind_x_ff[QW-1]}}, wind_x_ff};
         RegWindY:   prdata = {{(32-QW){wind_y_ff[QW-1]}}, wind_y_ff};
         RegGravity: prdata = {{(32-QW){gravity_ff[QW-1]}}, gravity_ff};
         default:    prdata = '0;
      endcase
   end

   ppi_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   ppi_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_kind           (req_kind),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_vel_x          (req_vel_x),
      .req_vel_y          (req_vel_y),
      .req_radius         (req_radius),
      .req_life           (req_life),
      .req_follows_camera (req_follows_camera),
      .req_scroll_offset  (req_scroll_offset),
      .force_enable       (force_ff),
      .wind_x             (wind_x_ff),
      .wind_y             (wind_y_ff),
      .gravity            (gravity_ff),
      .rsp_valid          (rsp_valid),
      .rsp_slot           (rsp_slot),
      .rsp_left           (rsp_left),
      .rsp_right          (rsp_right),
      .rsp_top            (rsp_top),
      .rsp_bottom         (rsp_bottom),
      .rsp_alpha          (rsp_alpha),
      .rsp_last           (rsp_last)
   );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for particle_pool_integrator: a directed table of
// spawns and ticks, then random traffic in three phases, two of them idling,
// under several force settings. Results are checked against a model or typed-in box.
// ----------------------------------------------------------------------------
module tb_top;
   import ppi_pkg::*;

   typedef struct {
      bit                      kind;
      logic signed [QW-1:0]    px, py, vx, vy;
      logic [RadiusW-1:0]      rad;
      logic [LifeW-1:0]        life;
      bit                      cam;
      logic signed [QW-1:0]    scroll;
   } item_type;

   typedef struct packed {
      logic [SlotW-1:0]          slot;
      logic signed [CornerW-1:0] left, right, top, bottom;
      logic [AlphaW-1:0]         alpha;
      logic                      last;
   } box_type;

   typedef struct {
      item_type it;
      bit       known;   // single result typed in below
      box_type  res;
   } row_type;

   localparam bit KIND_TICK = 1'b0;
   localparam bit KIND_SPAWN = 1'b1;
   localparam int QMAX = 8388607;
   localparam int QMIN = -8388608;
   localparam int WDOG_LIMIT = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_kind = 1'b0;
   logic signed [QW-1:0] req_pos_x = '0, req_pos_y = '0, req_vel_x = '0, req_vel_y = '0;
   logic [RadiusW-1:0] req_radius = '0;
   logic [LifeW-1:0] req_life = '0;
   logic req_follows_camera = 1'b0;
   logic signed [QW-1:0] req_scroll_offset = '0;
   logic rsp_valid;
   logic [SlotW-1:0] rsp_slot;
   logic signed [CornerW-1:0] rsp_left, rsp_right, rsp_top, rsp_bottom;
   logic [AlphaW-1:0] rsp_alpha;
   logic rsp_last;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CsrAddrW-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   particle_pool_integrator dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // model state
   bit   m_force;
   int   m_wind_x, m_wind_y, m_gravity;
   bit   m_used[PoolSize];
   int   m_x[PoolSize], m_y[PoolSize], m_vx[PoolSize], m_vy[PoolSize];
   int   m_rad[PoolSize], m_life[PoolSize], m_alpha[PoolSize], m_fade[PoolSize];
   bit   m_cam[PoolSize];

   box_type pending_boxes[$];
   int   errors = 0;
   int   idle_cycles = 0;

   function automatic int sat24(longint s);
      if (s > QMAX) return QMAX;
      if (s < QMIN) return QMIN;
      return int'(s);
   endfunction

   // advance the pool model by one item; returns the boxes it emits
   function automatic void integrate(item_type it, ref box_type boxes[$]);
      int i, l;
      boxes = {};
      if (it.kind == KIND_SPAWN) begin
         for (i = 0; i < PoolSize; i++) begin
            if (!m_used[i]) begin
               l = (it.life == 0) ? 1 : int'(it.life);
               m_x[i] = it.px; m_y[i] = it.py;
               m_vx[i] = it.vx; m_vy[i] = it.vy;
               m_rad[i] = it.rad; m_life[i] = l;
               m_alpha[i] = 255; m_fade[i] = 255 / l;
               m_cam[i] = it.cam; m_used[i] = 1'b1;
               break;
            end
         end
         return;
      end
      for (i = 0; i < PoolSize; i++) begin
         if (!m_used[i]) continue;
         if (m_force) begin
            m_vx[i] = sat24(longint'(m_vx[i]) + m_wind_x);
            m_vy[i] = sat24(longint'(m_vy[i]) + m_wind_y);
            m_vy[i] = sat24(longint'(m_vy[i]) + m_gravity);
         end
         m_x[i] = sat24(longint'(m_x[i]) + m_vx[i]);
         m_y[i] = sat24(longint'(m_y[i]) + m_vy[i]);
         m_life[i] = m_life[i] - 1;
         m_alpha[i] = (m_alpha[i] > m_fade[i]) ? m_alpha[i] - m_fade[i] : 0;
         if (m_life[i] == 0) m_used[i] = 1'b0;
      end
      for (i = 0; i < PoolSize; i++) begin
         box_type b;
         int off;
         if (!m_used[i]) continue;
         off = m_cam[i] ? int'(it.scroll) : 0;
         b.slot = SlotW'(i);
         b.left = CornerW'(m_x[i] - m_rad[i] - off);
         b.right = CornerW'(m_x[i] + m_rad[i] - off);
         b.top = CornerW'(m_y[i] - m_rad[i]);
         b.bottom = CornerW'(m_y[i] + m_rad[i]);
         b.alpha = AlphaW'(m_alpha[i]);
         b.last = 1'b0;
         boxes.push_back(b);
      end
      if (boxes.size() > 0) boxes[boxes.size()-1].last = 1'b1;
   endfunction

   // result checker; results cannot be held off
   always @(posedge clock) begin
      box_type got, want;
      if (!reset && rsp_valid) begin
         got = '{rsp_slot, rsp_left, rsp_right, rsp_top, rsp_bottom, rsp_alpha, rsp_last};
         if (pending_boxes.size() == 0) begin
            errors++;
            $display("%0t unexpected result transfer: expected none, actual %p", $time, got);
         end else begin
            want = pending_boxes.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t mismatch: expected %p, actual %p", $time, want, got);
            end
         end
      end
   end

   // watchdog on cycles with no transfer at all
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_item(item_type it, bit known, box_type res);
      box_type boxes[$];
      req_kind <= it.kind;
      req_pos_x <= it.px; req_pos_y <= it.py;
      req_vel_x <= it.vx; req_vel_y <= it.vy;
      req_radius <= it.rad; req_life <= it.life;
      req_follows_camera <= it.cam;
      req_scroll_offset <= it.scroll;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      integrate(it, boxes);
      if (known) pending_boxes.push_back(res);
      else foreach (boxes[k]) pending_boxes.push_back(boxes[k]);
   endtask

   task automatic pause(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // sender holds off until all results are in and the block has settled
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_boxes.size() != 0 || busy) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, int value);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         RegForce:   m_force = value[0];
         RegWindX:   m_wind_x = int'(signed'(value[QW-1:0]));
         RegWindY:   m_wind_y = int'(signed'(value[QW-1:0]));
         RegGravity: m_gravity = int'(signed'(value[QW-1:0]));
         default: ;
      endcase
   endtask

   task automatic set_forces(bit f, int wx, int wy, int g);
      drain();
      csr_write(RegForce, f);
      csr_write(RegWindX, wx);
      csr_write(RegWindY, wy);
      csr_write(RegGravity, g);
   endtask

   function automatic item_type mk(bit kind, int px, int py, int vx, int vy, int rad,
                                   int life, bit cam, int scroll);
      item_type it;
      it.kind = kind; it.px = QW'(px); it.py = QW'(py); it.vx = QW'(vx); it.vy = QW'(vy);
      it.rad = RadiusW'(rad); it.life = LifeW'(life); it.cam = cam;
      it.scroll = QW'(scroll);
      return it;
   endfunction

   function automatic item_type rand_item();
      item_type it;
      int r;
      it.kind = ($urandom_range(99) < 55) ? KIND_SPAWN : KIND_TICK;
      it.px = QW'($urandom); it.py = QW'($urandom);
      it.vx = ($urandom_range(3) == 0) ? QW'($urandom) : QW'($urandom_range(4095) - 2048);
      it.vy = ($urandom_range(3) == 0) ? QW'($urandom) : QW'($urandom_range(4095) - 2048);
      it.rad = RadiusW'($urandom);
      r = $urandom_range(99);
      it.life = (r < 10) ? LifeW'(0) : (r < 80) ? LifeW'($urandom_range(12, 1))
                                                : LifeW'($urandom);
      it.cam = 1'($urandom);
      it.scroll = QW'($urandom);
      return it;
   endfunction

   row_type dir_rows[$];
   box_type none;

   initial begin
      row_type row;
      int sender_gap;
      m_force = 1'b1;
      m_wind_x = 0; m_wind_y = 0; m_gravity = 0;
      foreach (m_used[i]) m_used[i] = 1'b0;
      none = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      row.known = 0; row.res = none;
      row.it = mk(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0);             dir_rows.push_back(row);
      row.it = mk(KIND_SPAWN, 25600, 12800, 0, 0, 256, 2, 0, 0);  dir_rows.push_back(row);
      row.it = mk(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 1000);
      row.known = 1;
      row.res = '{6'd0, 26'sd25344, 26'sd25856, 26'sd12544, 26'sd13056, 8'd128, 1'b1};
      dir_rows.push_back(row);
      row.known = 0; row.res = none;
      row.it = mk(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0);             dir_rows.push_back(row);
      row.it = mk(KIND_SPAWN, 5, 5, 1, 1, 1, 0, 1, 0);            dir_rows.push_back(row);
      row.it = mk(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0);             dir_rows.push_back(row);
      row.it = mk(KIND_SPAWN, QMAX, QMAX, QMAX, QMAX, 65535, 1023, 1, 0);
      dir_rows.push_back(row);
      row.it = mk(KIND_SPAWN, QMIN, QMIN, QMIN, QMIN, 0, 1023, 0, 0);
      dir_rows.push_back(row);
      row.it = mk(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, QMAX);          dir_rows.push_back(row);
      row.it = mk(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, QMIN);          dir_rows.push_back(row);
      row.it = mk(KIND_SPAWN, 0, 0, -256, 512, 128, 3, 1, 0);     dir_rows.push_back(row);
      row.it = mk(KIND_SPAWN, -1000, 700, 3, -3, 65535, 255, 1, 0);
      dir_rows.push_back(row);
      row.it = mk(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, -77);           dir_rows.push_back(row);
      row.it = mk(KIND_SPAWN, 1, 2, 3, 4, 5, 256, 0, 0);          dir_rows.push_back(row);
      row.it = mk(KIND_TICK, 0, 0, 0, 0, 0, 0, 1, 4096);          dir_rows.push_back(row);
      row.it = mk(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0);             dir_rows.push_back(row);
      foreach (dir_rows[k]) send_item(dir_rows[k].it, dir_rows[k].known, dir_rows[k].res);

      // random phases: sender gap 21, 52, then none in a hundred
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               set_forces(1'b1, QMAX, QMIN, 300);
               sender_gap = 21;
            end
            1: begin
               set_forces(1'b0, QMIN, QMAX, QMIN);
               sender_gap = 52;
               // fill the pool past its end so the extra spawns are dropped
               for (int k = 0; k < 66; k++)
                  send_item(mk(KIND_SPAWN, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom_range(40, 20), 1'($urandom), 0),
                            0, none);
            end
            default: begin
               set_forces(1'b1, $urandom_range(511) - 256, $urandom_range(511) - 256,
                          QMAX);
               sender_gap = 0;
            end
         endcase
         for (int k = 0; k < 75; k++) begin
            send_item(rand_item(), 0, none);
            if ($urandom_range(99) < sender_gap) pause($urandom_range(8, 1));
         end
      end
      set_forces(1'b1, 0, 0, 0);

      drain();
      repeat (20) @(posedge clock);
      if (errors == 0 && pending_boxes.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
